// ===== sv/sqei_pkg.sv =====
// Shared types and constants for the segment / quad edge intersect unit.
// No dependencies.
package sqei_pkg;

   localparam int unsigned NUM_EDGES = 4;

   // Per-stage load enables, produced by the top-level ready chain.
   typedef struct packed {
      logic en_s1;
      logic en_s2;
      logic en_s3;
      logic en_s4;
      logic en_s5;
   } stage_ctl_type;

endpackage

// ===== sv/sqei_lane.sv =====
// One edge-versus-segment lane: differences, products, determinants, verdict.
// Depends on sqei_pkg (stage_ctl_type).
module sqei_lane
   import sqei_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  stage_ctl_type                ctl,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] c_x,
   input  logic signed [COORD_BITS-1:0] c_y,
   input  logic signed [COORD_BITS-1:0] d_x,
   input  logic signed [COORD_BITS-1:0] d_y,
   output logic                         lane_hit
);

   localparam int DW = COORD_BITS + 1;       // coordinate differences
   localparam int PW = 2 * COORD_BITS + 2;   // products
   localparam int SW = 2 * COORD_BITS + 3;   // determinants

   // S1: differences and per-axis bounds
   logic signed [DW-1:0] rx_ff, ry_ff, sx_ff, sy_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] rx_in, ry_in, sx_in, sy_in, wx_in, wy_in;
   logic signed [COORD_BITS-1:0] elo_x_ff, ehi_x_ff, elo_y_ff, ehi_y_ff;
   logic signed [COORD_BITS-1:0] slo_x_ff, shi_x_ff, slo_y_ff, shi_y_ff;

   assign rx_in = DW'(b_x) - DW'(a_x);
   assign ry_in = DW'(b_y) - DW'(a_y);
   assign sx_in = DW'(d_x) - DW'(c_x);
   assign sy_in = DW'(d_y) - DW'(c_y);
   assign wx_in = DW'(c_x) - DW'(a_x);
   assign wy_in = DW'(c_y) - DW'(a_y);

   always_ff @(posedge clock) begin
      if (ctl.en_s1) begin
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         elo_x_ff <= (a_x < b_x) ? a_x : b_x;
         ehi_x_ff <= (a_x < b_x) ? b_x : a_x;
         elo_y_ff <= (a_y < b_y) ? a_y : b_y;
         ehi_y_ff <= (a_y < b_y) ? b_y : a_y;
         slo_x_ff <= (c_x < d_x) ? c_x : d_x;
         shi_x_ff <= (c_x < d_x) ? d_x : c_x;
         slo_y_ff <= (c_y < d_y) ? c_y : d_y;
         shi_y_ff <= (c_y < d_y) ? d_y : c_y;
      end
   end

   // S2: six products, box overlap, degenerate flags
   logic signed [PW-1:0] p_rs_ff, p_qs_ff, p_ws_ff, p_vs_ff, p_wr_ff, p_vr_ff;
   logic signed [PW-1:0] p_rs_in, p_qs_in, p_ws_in, p_vs_in, p_wr_in, p_vr_in;
   logic rng_ok_s2_ff, degen_s2_ff;

   assign p_rs_in = rx_ff * sy_ff;
   assign p_qs_in = ry_ff * sx_ff;
   assign p_ws_in = wx_ff * sy_ff;
   assign p_vs_in = wy_ff * sx_ff;
   assign p_wr_in = wx_ff * ry_ff;
   assign p_vr_in = wy_ff * rx_ff;

   always_ff @(posedge clock) begin
      if (ctl.en_s2) begin
         p_rs_ff      <= p_rs_in;
         p_qs_ff      <= p_qs_in;
         p_ws_ff      <= p_ws_in;
         p_vs_ff      <= p_vs_in;
         p_wr_ff      <= p_wr_in;
         p_vr_ff      <= p_vr_in;
         rng_ok_s2_ff <= (elo_x_ff <= shi_x_ff) && (slo_x_ff <= ehi_x_ff) &&
                         (elo_y_ff <= shi_y_ff) && (slo_y_ff <= ehi_y_ff);
         degen_s2_ff  <= (rx_ff == '0 && ry_ff == '0) || (sx_ff == '0 && sy_ff == '0);
      end
   end

   // S3: denominator and the two numerators
   logic signed [SW-1:0] den_ff, tn_ff, un_ff;
   logic rng_ok_s3_ff, degen_s3_ff;

   always_ff @(posedge clock) begin
      if (ctl.en_s3) begin
         den_ff       <= SW'(p_rs_ff) - SW'(p_qs_ff);
         tn_ff        <= SW'(p_ws_ff) - SW'(p_vs_ff);
         un_ff        <= SW'(p_wr_ff) - SW'(p_vr_ff);
         rng_ok_s3_ff <= rng_ok_s2_ff;
         degen_s3_ff  <= degen_s2_ff;
      end
   end

   // S4: both ratios inside [0,1], or, when den is zero, collinear or degenerate overlap.
   // The collinear cross product is -un, so its zero test reuses un.
   logic den_zero, den_neg, t_ok, u_ok, hit_in, lane_hit_ff;

   assign den_zero = (den_ff == '0);
   assign den_neg  = den_ff[SW-1];
   assign t_ok = den_neg ? (tn_ff[SW-1] || tn_ff == '0) && (tn_ff >= den_ff)
                         : !tn_ff[SW-1] && (tn_ff <= den_ff);
   assign u_ok = den_neg ? (un_ff[SW-1] || un_ff == '0) && (un_ff >= den_ff)
                         : !un_ff[SW-1] && (un_ff <= den_ff);
   assign hit_in = den_zero ? ((degen_s3_ff || un_ff == '0) && rng_ok_s3_ff)
                            : (t_ok && u_ok);

   always_ff @(posedge clock) begin
      if (ctl.en_s4) begin
         lane_hit_ff <= hit_in;
      end
   end

   assign lane_hit = lane_hit_ff;

endmodule

// ===== sv/sqei_merge.sv =====
// Merge stage: folds the four lane verdicts into the result word register.
// Depends on sqei_pkg (stage_ctl_type, NUM_EDGES).
module sqei_merge
   import sqei_pkg::*;
(
   input  logic                 clock,
   input  stage_ctl_type        ctl,
   input  logic [NUM_EDGES-1:0] lane_hits,
   output logic                 hit,
   output logic [NUM_EDGES-1:0] edge_hits
);

   logic                 hit_ff;
   logic [NUM_EDGES-1:0] edge_hits_ff;

   always_ff @(posedge clock) begin
      if (ctl.en_s5) begin
         hit_ff       <= |lane_hits;
         edge_hits_ff <= lane_hits;
      end
   end

   assign hit       = hit_ff;
   assign edge_hits = edge_hits_ff;

endmodule

// ===== sv/segment_quad_edge_intersect_unit.sv =====
// A request word passes the S0 to S5 registers in order before its result word is valid.
// Throughput: one word per cycle; stalls only while the output register holds a word
// that rsp_ready does not take and every stage behind it is occupied.
// The critical stage is the lane multiplier bank (one product per register).
// Reset (synchronous, active high) clears all stage valid bits; payload is not reset.
module segment_quad_edge_intersect_unit
   import sqei_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_corner0_x,
   input  logic signed [COORD_BITS-1:0] req_corner0_y,
   input  logic signed [COORD_BITS-1:0] req_corner1_x,
   input  logic signed [COORD_BITS-1:0] req_corner1_y,
   input  logic signed [COORD_BITS-1:0] req_corner2_x,
   input  logic signed [COORD_BITS-1:0] req_corner2_y,
   input  logic signed [COORD_BITS-1:0] req_corner3_x,
   input  logic signed [COORD_BITS-1:0] req_corner3_y,
   input  logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [NUM_EDGES-1:0]         rsp_edge_hits
);

   // Pipeline:
   //   S0 input register, S1 differences/bounds, S2 products, S3 determinants,
   //   S4 per-lane verdict, S5 merged result (output register).
   // Each stage loads when it is empty or the stage after it moves, so
   // bubbles collapse and a waiting result blocks new requests only once every stage is full.

   logic [5:0] vld_ff, vld_in;
   logic [5:0] rdy;
   stage_ctl_type ctl;

   always_comb begin
      rdy[5] = !vld_ff[5] || rsp_ready;
      for (int k = 4; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[0];

   assign ctl.en_s1 = rdy[1];
   assign ctl.en_s2 = rdy[2];
   assign ctl.en_s3 = rdy[3];
   assign ctl.en_s4 = rdy[4];
   assign ctl.en_s5 = rdy[5];

   always_comb begin
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = req_valid;
      end
      for (int k = 1; k < 6; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // S0: request word capture
   logic signed [COORD_BITS-1:0] corner_x_ff [NUM_EDGES];
   logic signed [COORD_BITS-1:0] corner_y_ff [NUM_EDGES];
   logic signed [COORD_BITS-1:0] seg_sx_ff, seg_sy_ff, seg_ex_ff, seg_ey_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         corner_x_ff[0] <= req_corner0_x;
         corner_y_ff[0] <= req_corner0_y;
         corner_x_ff[1] <= req_corner1_x;
         corner_y_ff[1] <= req_corner1_y;
         corner_x_ff[2] <= req_corner2_x;
         corner_y_ff[2] <= req_corner2_y;
         corner_x_ff[3] <= req_corner3_x;
         corner_y_ff[3] <= req_corner3_y;
         seg_sx_ff      <= req_seg_start_x;
         seg_sy_ff      <= req_seg_start_y;
         seg_ex_ff      <= req_seg_end_x;
         seg_ey_ff      <= req_seg_end_y;
      end
   end

   // One lane per edge: corner i to corner (i+1) mod 4.
   logic [NUM_EDGES-1:0] lane_hits;

   for (genvar i = 0; i < NUM_EDGES; i++) begin : g_lane
      localparam int J = (i + 1) % NUM_EDGES;
      sqei_lane #(
         .COORD_BITS(COORD_BITS)
      ) u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .a_x     (corner_x_ff[i]),
         .a_y     (corner_y_ff[i]),
         .b_x     (corner_x_ff[J]),
         .b_y     (corner_y_ff[J]),
         .c_x     (seg_sx_ff),
         .c_y     (seg_sy_ff),
         .d_x     (seg_ex_ff),
         .d_y     (seg_ey_ff),
         .lane_hit(lane_hits[i])
      );
   end

   sqei_merge u_merge (
      .clock    (clock),
      .ctl      (ctl),
      .lane_hits(lane_hits),
      .hit      (rsp_hit),
      .edge_hits(rsp_edge_hits)
   );

   assign rsp_valid = vld_ff[5];

endmodule

// ===== sv/sqei_checker.sv =====
// Port-level checks for the segment / quad edge intersect unit, bound to the top.
// Depends on sqei_pkg (NUM_EDGES) and segment_quad_edge_intersect_unit.
module sqei_checker
   import sqei_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [NUM_EDGES-1:0] rsp_edge_hits
);

   // Reset empties the output register.
   a_reset_clears : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A stalled result word holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_edge_hits))
      else $error("stalled result word changed");

   // The summary bit agrees with the edge mask.
   a_hit_merge : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit == (rsp_edge_hits != '0))
      else $error("rsp_hit disagrees with rsp_edge_hits");

   // With the output register empty the pipeline can always take a word.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low while output register empty");

endmodule

bind segment_quad_edge_intersect_unit sqei_checker u_sqei_checker (.*);

// ===== verif/sqei_hit_checker.sv =====
// Checker for the segment / quad edge intersect unit: predicts hit and edge mask per word.
// Depends on sqei_pkg (NUM_EDGES).
`timescale 1ns / 1ps

module sqei_hit_checker
   import sqei_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_corner0_x,
   input  logic signed [COORD_BITS-1:0] req_corner0_y,
   input  logic signed [COORD_BITS-1:0] req_corner1_x,
   input  logic signed [COORD_BITS-1:0] req_corner1_y,
   input  logic signed [COORD_BITS-1:0] req_corner2_x,
   input  logic signed [COORD_BITS-1:0] req_corner2_y,
   input  logic signed [COORD_BITS-1:0] req_corner3_x,
   input  logic signed [COORD_BITS-1:0] req_corner3_y,
   input  logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_hit,
   input  logic [NUM_EDGES-1:0]         rsp_edge_hits,
   output int                           fail_count,
   output int                           words_in_flight
);

   typedef struct packed {
      logic                 hit;
      logic [NUM_EDGES-1:0] edge_hits;
   } hit_word_type;

   hit_word_type hits_due[$];

   initial begin
      fail_count      = 0;
      words_in_flight = 0;
   end

   // closed intervals [p0,p1] and [q0,q1] share a point
   function automatic bit spans_meet(input longint p0, p1, q0, q1);
      longint t;
      if (p0 > p1) begin
         t  = p0;
         p0 = p1;
         p1 = t;
      end
      if (q0 > q1) begin
         t  = q0;
         q0 = q1;
         q1 = t;
      end
      return ((p0 > q0) ? p0 : q0) <= ((p1 < q1) ? p1 : q1);
   endfunction

   // num/den in [0,1], den non-zero, no division
   function automatic bit in_unit(input longint num, den);
      if (den > 0)
         return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   // closed segment a-b against closed segment c-d
   function automatic bit edge_meets(input longint ax, ay, bx, by, cx, cy, dx, dy);
      longint rx, ry, sx, sy, wx, wy, den, tn, un;
      bit     on_line;
      rx  = bx - ax;
      ry  = by - ay;
      sx  = dx - cx;
      sy  = dy - cy;
      wx  = cx - ax;
      wy  = cy - ay;
      den = rx * sy - ry * sx;
      if (den != 0) begin
         tn = wx * sy - wy * sx;
         un = wx * ry - wy * rx;
         return in_unit(tn, den) && in_unit(un, den);
      end
      // parallel: a point segment always passes the line test, only boxes decide
      on_line = (rx == 0 && ry == 0) || (sx == 0 && sy == 0) || (rx * wy - ry * wx == 0);
      return on_line && spans_meet(ax, bx, cx, dx) && spans_meet(ay, by, cy, dy);
   endfunction

   always @(posedge clock) begin : track
      longint       qx[NUM_EDGES];
      longint       qy[NUM_EDGES];
      hit_word_type due;
      int           k;
      if (reset) begin
         hits_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hits_due.size() == 0) begin
               $display("%0t: result word with none expected: hit %0b edge_hits %b",
                        $time, rsp_hit, rsp_edge_hits);
               fail_count = fail_count + 1;
            end else begin
               due = hits_due.pop_front();
               if (rsp_hit !== due.hit) begin
                  $display("%0t: hit mismatch: expected %0b, actual %0b",
                           $time, due.hit, rsp_hit);
                  fail_count = fail_count + 1;
               end
               if (rsp_edge_hits !== due.edge_hits) begin
                  $display("%0t: edge_hits mismatch: expected %b, actual %b",
                           $time, due.edge_hits, rsp_edge_hits);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            qx[0] = req_corner0_x;
            qy[0] = req_corner0_y;
            qx[1] = req_corner1_x;
            qy[1] = req_corner1_y;
            qx[2] = req_corner2_x;
            qy[2] = req_corner2_y;
            qx[3] = req_corner3_x;
            qy[3] = req_corner3_y;
            for (k = 0; k < NUM_EDGES; k++)
               due.edge_hits[k] = edge_meets(qx[k], qy[k],
                                             qx[(k + 1) % NUM_EDGES], qy[(k + 1) % NUM_EDGES],
                                             req_seg_start_x, req_seg_start_y,
                                             req_seg_end_x, req_seg_end_y);
            due.hit = |due.edge_hits;
            hits_due.insert(hits_due.size(), due);
         end
      end
      words_in_flight = hits_due.size();
   end

endmodule

// ===== verif/segment_quad_edge_intersect_unit_test.sv =====
// Top of the segment / quad edge intersect unit test: clock, reset, word stimulus, verdict.
// Depends on sqei_pkg, segment_quad_edge_intersect_unit and sqei_hit_checker.
`timescale 1ns / 1ps

module segment_quad_edge_intersect_unit_test
   import sqei_pkg::*;
();

   localparam int COORD_BITS  = 16;
   localparam int RANDOM_WORDS = 1030;
   // cycles with no handshake on either side before we give up
   localparam int IDLE_LIMIT  = 2000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic   clock;
   logic   reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_corner0_x = '0;
   coord_type req_corner0_y = '0;
   coord_type req_corner1_x = '0;
   coord_type req_corner1_y = '0;
   coord_type req_corner2_x = '0;
   coord_type req_corner2_y = '0;
   coord_type req_corner3_x = '0;
   coord_type req_corner3_y = '0;
   coord_type req_seg_start_x = '0;
   coord_type req_seg_start_y = '0;
   coord_type req_seg_end_x = '0;
   coord_type req_seg_end_y = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [NUM_EDGES-1:0] rsp_edge_hits;

   int mismatches;
   int in_flight;
   int idle_cycles = 0;

   // when set, neither side inserts gaps (back to back stretches)
   bit steady = 1'b0;

   // 8 ns clock, first rising edge at 4 ns
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   segment_quad_edge_intersect_unit #(
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_corner0_x  (req_corner0_x),
      .req_corner0_y  (req_corner0_y),
      .req_corner1_x  (req_corner1_x),
      .req_corner1_y  (req_corner1_y),
      .req_corner2_x  (req_corner2_x),
      .req_corner2_y  (req_corner2_y),
      .req_corner3_x  (req_corner3_x),
      .req_corner3_y  (req_corner3_y),
      .req_seg_start_x(req_seg_start_x),
      .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x  (req_seg_end_x),
      .req_seg_end_y  (req_seg_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_edge_hits  (rsp_edge_hits)
   );

   sqei_hit_checker #(
      .COORD_BITS(COORD_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_corner0_x  (req_corner0_x),
      .req_corner0_y  (req_corner0_y),
      .req_corner1_x  (req_corner1_x),
      .req_corner1_y  (req_corner1_y),
      .req_corner2_x  (req_corner2_x),
      .req_corner2_y  (req_corner2_y),
      .req_corner3_x  (req_corner3_x),
      .req_corner3_y  (req_corner3_y),
      .req_seg_start_x(req_seg_start_x),
      .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x  (req_seg_end_x),
      .req_seg_end_y  (req_seg_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_edge_hits  (rsp_edge_hits),
      .fail_count     (mismatches),
      .words_in_flight(in_flight)
   );

   // Watchdog: count cycles where neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("** segment_quad_edge_intersect_unit: FAILED **");
      $finish;
   end

   // Result side: for every word, unless steady is set, draw a stall with ready low,
   // then hold ready high until a word is taken.
   initial begin : rsp_side
      int stall;
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         stall = steady ? 0 : $urandom_range(4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_valid);
      end
   end

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // values at and next to the ends of the 16-bit range, plus around zero
   function automatic int extreme_coord();
      case ($urandom_range(6))
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   // Drive one request word. Gap (valid low) drawn per word; with no gap the
   // valid stays high and only the payload changes at this falling edge.
   task automatic send_word(input int c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y,
                            input int s0x, s0y, s1x, s1y);
      int gap;
      gap = steady ? 0 : $urandom_range(4);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_corner0_x   <= coord_type'(c0x);
      req_corner0_y   <= coord_type'(c0y);
      req_corner1_x   <= coord_type'(c1x);
      req_corner1_y   <= coord_type'(c1y);
      req_corner2_x   <= coord_type'(c2x);
      req_corner2_y   <= coord_type'(c2y);
      req_corner3_x   <= coord_type'(c3x);
      req_corner3_y   <= coord_type'(c3y);
      req_seg_start_x <= coord_type'(s0x);
      req_seg_start_y <= coord_type'(s0y);
      req_seg_end_x   <= coord_type'(s1x);
      req_seg_end_y   <= coord_type'(s1y);
      req_valid       <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0)
         @(negedge clock);
   endtask

   // One random word. Most kinds are built so the segment lands on or near the
   // quad: crossings, endpoint touches, collinear runs, degenerate edges.
   task automatic random_word();
      int px[4], py[4];
      int sx, sy, ex, ey;
      int cx, cy, hw, hh, off_x, off_y;
      int i, j, t0, t1;
      int kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1: begin
            // noise over the full field range, every bit toggles
            for (i = 0; i < 4; i++) begin
               px[i] = span(-32768, 32767);
               py[i] = span(-32768, 32767);
            end
            sx = span(-32768, 32767);
            sy = span(-32768, 32767);
            ex = span(-32768, 32767);
            ey = span(-32768, 32767);
         end
         2, 3, 8: begin
            // tiny grid: parallel, collinear and touching pairs are common
            for (i = 0; i < 4; i++) begin
               px[i] = span(-6, 6);
               py[i] = span(-6, 6);
            end
            sx = span(-6, 6);
            sy = span(-6, 6);
            ex = span(-6, 6);
            ey = span(-6, 6);
            if (kind == 8) begin
               // force a point edge, a point segment, or both
               i = $urandom_range(3);
               j = (i + 1) % 4;
               t0 = $urandom_range(2);
               if (t0 != 1) begin
                  px[j] = px[i];
                  py[j] = py[i];
               end
               if (t0 != 0) begin
                  ex = sx;
                  ey = sy;
               end
            end
         end
         4, 7: begin
            // axis-aligned box, even half sizes so edge midpoints are integer
            cx = span(-20000, 20000);
            cy = span(-20000, 20000);
            hw = 2 * span(0, 2500);
            hh = 2 * span(0, 2500);
            px[0] = cx - hw;  py[0] = cy - hh;
            px[1] = cx + hw;  py[1] = cy - hh;
            px[2] = cx + hw;  py[2] = cy + hh;
            px[3] = cx - hw;  py[3] = cy + hh;
            if (kind == 4) begin
               sx = cx + span(-7000, 7000);
               sy = cy + span(-7000, 7000);
            end else begin
               // start exactly on a corner or an edge midpoint
               i = $urandom_range(3);
               j = (i + 1) % 4;
               if ($urandom_range(1) == 0) begin
                  sx = px[i];
                  sy = py[i];
               end else begin
                  sx = (px[i] + px[j]) / 2;
                  sy = (py[i] + py[j]) / 2;
               end
            end
            ex = cx + span(-12000, 12000);
            ey = cy + span(-12000, 12000);
         end
         5: begin
            // one corner per quadrant around a center, segment through it
            cx = span(-20000, 20000);
            cy = span(-20000, 20000);
            px[0] = cx - span(0, 3000);  py[0] = cy - span(0, 3000);
            px[1] = cx + span(0, 3000);  py[1] = cy - span(0, 3000);
            px[2] = cx + span(0, 3000);  py[2] = cy + span(0, 3000);
            px[3] = cx - span(0, 3000);  py[3] = cy + span(0, 3000);
            off_x = span(-6000, 6000);
            off_y = span(-6000, 6000);
            sx = cx + off_x;
            sy = cy + off_y;
            ex = cx - off_x + span(-40, 40);
            ey = cy - off_y + span(-40, 40);
         end
         6: begin
            // segment on the line of one edge, integer multiples of its direction
            for (i = 0; i < 4; i++) begin
               px[i] = span(-100, 100);
               py[i] = span(-100, 100);
            end
            i  = $urandom_range(3);
            j  = (i + 1) % 4;
            t0 = span(-2, 3);
            t1 = span(-2, 3);
            sx = px[i] + t0 * (px[j] - px[i]);
            sy = py[i] + t0 * (py[j] - py[i]);
            ex = px[i] + t1 * (px[j] - px[i]);
            ey = py[i] + t1 * (py[j] - py[i]);
         end
         default: begin
            for (i = 0; i < 4; i++) begin
               px[i] = extreme_coord();
               py[i] = extreme_coord();
            end
            sx = extreme_coord();
            sy = extreme_coord();
            ex = extreme_coord();
            ey = extreme_coord();
         end
      endcase
      send_word(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3], sx, sy, ex, ey);
   endtask

   initial begin : stimulus
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words. Square of side 20 around the origin unless noted;
      // edge 0 bottom, 1 right, 2 top, 3 left.
      send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                 // everything a point
      send_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                32767, 32767, 32767, 32767);
      send_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768, -32768);
      // full-range square, diagonal touching two corners
      send_word(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                -32768, -32768, 32767, 32767);
      // full-range square, horizontal across, endpoints on left and right edges
      send_word(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                -32768, 0, 32767, 0);
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 0, 0, 5, 5);     // inside, no hit
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 0, 0, 20, 0);    // crosses right
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 0, 0, 10, 3);    // endpoint on right
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, -20, -20, 20, 20); // through corners
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, -5, -12, 5, -12);  // parallel, apart
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, -5, -10, 5, -10);  // collinear overlap
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 12, -10, 20, -10); // collinear, disjoint
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 10, -10, 20, -10); // collinear, end touch
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 3, -10, 3, -10);   // point on bottom
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, 3, 3, 3, 3);       // point inside
      send_word(-10, -10, 10, -10, 10, 10, -10, 10, -12, -20, -12, 20); // parallel to left
      // point edge lying on the segment
      send_word(-10, -10, -10, -10, 10, 10, -10, 10, -20, -10, 0, -10);
      // point edge inside the segment's box but off its line: still a hit
      send_word(1, 2, 1, 2, 8, 2, 8, 9, 0, 0, 4, 4);
      // bow-tie at the range corners, long diagonal: largest products
      send_word(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768,
                -32768, -32767, 32767, 32766);
      send_word(-32768, 100, 32767, -100, 32767, 32767, -32768, -32768,
                0, -32768, 0, 32767);

      // let the pipe empty completely before the random part
      drain();

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0)
            steady = ($urandom_range(3) == 0);
         random_word();
      end

      drain();
      // leave room for anything stray
      repeat (12) @(negedge clock);
      if (mismatches == 0)
         $display("** segment_quad_edge_intersect_unit: PASSED **");
      else
         $display("** segment_quad_edge_intersect_unit: FAILED **");
      $finish;
   end

endmodule
